### src/assert_macros.svh
// assertion macros for the rtl files, included by the sequencer
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property checked on every rising edge of clk, off while in reset
`define ASSERT_CLK(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// expression that must never be true on a rising edge of clk
`define ASSERT_NEVER(label, expr, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) else $error(msg);

`endif

### src/efsd_pkg.sv
// types and constants of the earliest free server dispatch core
package efsd_pkg;

  localparam int MAX_SERVERS_DEF = 64;
  localparam int TIME_WIDTH_DEF  = 48;

  localparam int DUR_W    = 32;
  localparam int SERVER_W = 7;
  localparam int START_W  = 48;
  localparam int CFG_W    = 7;
  localparam int APB_DW   = 32;
  localparam int APB_AW   = 3;

  // action codes
  localparam logic ACT_JOB = 1'b0;
  localparam logic ACT_END = 1'b1;

  // register index, taken from the word address
  localparam logic [APB_AW-3:0] REG_SERVERS_IN_USE = '0;

  localparam logic [CFG_W-1:0] SERVERS_IN_USE_RST = CFG_W'(1);

  typedef struct packed {
    logic             action;
    logic [DUR_W-1:0] duration;
  } in_word_t;

  typedef struct packed {
    logic [SERVER_W-1:0] assigned_server;
    logic [START_W-1:0]  start_time;
    logic [SERVER_W-1:0] next_server;
    logic                time_saturated;
  } out_word_t;

endpackage

### src/efsd_ftmem.sv
// finish time memory, one write and one registered read port
module efsd_ftmem import efsd_pkg::*; #(
  parameter  int DEPTH = MAX_SERVERS_DEF,
  parameter  int WIDTH = TIME_WIDTH_DEF,
  localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             wr_en,
  input  logic [AW-1:0]    wr_addr,
  input  logic [WIDTH-1:0] wr_data,
  input  logic             rd_en,
  input  logic [AW-1:0]    rd_addr,
  output logic [WIDTH-1:0] rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

### src/efsd_seq.sv
// dispatch sequencer: minimum scan over the finish times, update and result
module efsd_seq import efsd_pkg::*; #(
  parameter  int MAX_SERVERS = MAX_SERVERS_DEF,
  parameter  int TIME_WIDTH  = TIME_WIDTH_DEF,
  localparam int IW          = (MAX_SERVERS > 1) ? $clog2(MAX_SERVERS) : 1,
  localparam int CW          = $clog2(MAX_SERVERS + 1)
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic [CW-1:0]         n_act,
  input  logic                  in_valid,
  input  in_word_t              in_word,
  output logic                  in_stall,
  output logic                  rd_en,
  output logic [IW-1:0]         rd_addr,
  input  logic [TIME_WIDTH-1:0] rd_data,
  output logic                  wr_en,
  output logic [IW-1:0]         wr_addr,
  output logic [TIME_WIDTH-1:0] wr_data,
  output logic                  res_valid,
  input  logic                  res_ready,
  output out_word_t             res_word
);

`include "assert_macros.svh"

  localparam int SUM_W = ((TIME_WIDTH > DUR_W) ? TIME_WIDTH : DUR_W) + 1;
  localparam logic [SUM_W-1:0] TIME_MAX = SUM_W'({TIME_WIDTH{1'b1}});

  typedef enum logic [2:0] {
    ST_IDLE  = 3'b001,
    ST_SCAN  = 3'b010,
    ST_APPLY = 3'b100
  } seq_state_t;

  seq_state_t            state_r, state_nxt;
  logic                  act_r, act_nxt;
  logic                  fill_r, fill_nxt;
  logic [DUR_W-1:0]      dur_r, dur_nxt;
  logic [CW-1:0]         n_r, n_nxt;
  logic [CW-1:0]         used_r, used_nxt;
  logic [CW-1:0]         rd_cnt_r, rd_cnt_nxt;
  logic [CW-1:0]         cmp_cnt_r, cmp_cnt_nxt;
  logic                  pend_r, pend_nxt;
  logic [TIME_WIDTH-1:0] best_r, best_nxt;
  logic [IW-1:0]         best_idx_r, best_idx_nxt;

  logic                  accept;
  logic                  take;
  logic                  last;
  logic [SUM_W-1:0]      sum;
  logic                  sat;
  logic [TIME_WIDTH-1:0] fin;
  logic [IW:0]           srv_num;

  assign in_stall = (state_r != ST_IDLE);
  assign accept   = in_valid && !in_stall;

  // scan compare, lowest index wins a tie
  assign take = pend_r && ((cmp_cnt_r == '0) || (rd_data < best_r));
  assign last = pend_r && (cmp_cnt_r == n_r - CW'(1));

  // finish time with clamp
  assign sum     = SUM_W'(best_r) + SUM_W'(dur_r);
  assign sat     = (sum > TIME_MAX);
  assign fin     = sat ? {TIME_WIDTH{1'b1}} : TIME_WIDTH'(sum);
  assign srv_num = {1'b0, best_idx_r} + (IW+1)'(1);

  always_comb begin
    state_nxt    = state_r;
    act_nxt      = act_r;
    fill_nxt     = fill_r;
    dur_nxt      = dur_r;
    n_nxt        = n_r;
    used_nxt     = used_r;
    rd_cnt_nxt   = rd_cnt_r;
    cmp_cnt_nxt  = cmp_cnt_r;
    pend_nxt     = 1'b0;
    best_nxt     = best_r;
    best_idx_nxt = best_idx_r;
    rd_en        = 1'b0;
    rd_addr      = '0;
    wr_en        = 1'b0;
    wr_addr      = best_idx_r;
    wr_data      = fin;
    res_valid    = 1'b0;
    res_word     = '0;

    unique case (state_r)
      ST_IDLE: begin
        if (accept) begin
          act_nxt  = in_word.action;
          dur_nxt  = in_word.duration;
          n_nxt    = n_act;
          fill_nxt = (used_r < n_act);
          if (used_r < n_act) begin
            // unused server left: it starts at time zero
            best_nxt     = '0;
            best_idx_nxt = used_r[IW-1:0];
            state_nxt    = ST_APPLY;
          end else begin
            rd_en       = 1'b1;
            rd_addr     = '0;
            rd_cnt_nxt  = CW'(1);
            cmp_cnt_nxt = '0;
            pend_nxt    = 1'b1;
            state_nxt   = ST_SCAN;
          end
        end
      end
      ST_SCAN: begin
        if (rd_cnt_r < n_r) begin
          rd_en      = 1'b1;
          rd_addr    = rd_cnt_r[IW-1:0];
          rd_cnt_nxt = rd_cnt_r + CW'(1);
          pend_nxt   = 1'b1;
        end
        if (take) begin
          best_nxt     = rd_data;
          best_idx_nxt = cmp_cnt_r[IW-1:0];
        end
        if (pend_r) begin
          cmp_cnt_nxt = cmp_cnt_r + CW'(1);
        end
        if (last) begin
          state_nxt = ST_APPLY;
        end
      end
      ST_APPLY: begin
        res_valid = 1'b1;
        if (act_r == ACT_END) begin
          res_word.next_server = SERVER_W'(srv_num);
        end else begin
          res_word.assigned_server = SERVER_W'(srv_num);
          res_word.start_time      = START_W'(best_r);
          res_word.time_saturated  = sat;
        end
        if (res_ready) begin
          state_nxt = ST_IDLE;
          if (act_r == ACT_END) begin
            used_nxt = '0;
          end else begin
            wr_en = 1'b1;
            if (fill_r) begin
              used_nxt = used_r + CW'(1);
            end
          end
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= ST_IDLE;
      used_r    <= '0;
      pend_r    <= 1'b0;
      rd_cnt_r  <= '0;
      cmp_cnt_r <= '0;
    end else begin
      state_r   <= state_nxt;
      used_r    <= used_nxt;
      pend_r    <= pend_nxt;
      rd_cnt_r  <= rd_cnt_nxt;
      cmp_cnt_r <= cmp_cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    act_r      <= act_nxt;
    fill_r     <= fill_nxt;
    dur_r      <= dur_nxt;
    n_r        <= n_nxt;
    best_r     <= best_nxt;
    best_idx_r <= best_idx_nxt;
  end

  `ASSERT_CLK(a_used_bound, used_r <= CW'(MAX_SERVERS), "fill count beyond server count")
  `ASSERT_CLK(a_accept_busy, accept |=> (state_r != ST_IDLE), "accepted word not in progress")
  `ASSERT_CLK(a_scan_data, (state_r == ST_SCAN) |-> (pend_r && (cmp_cnt_r < n_r)), "scan out of step")
  `ASSERT_NEVER(a_double_write, wr_en && $past(wr_en), "finish time written twice for one word")

endmodule

### src/earliest_free_server_dispatch_core.sv
// earliest free server dispatch core: config register, sequencer, memory, output register
//
//  channel | direction | handshake              | payload
//  --------+-----------+------------------------+----------------------------------------
//  in_     | input     | in_valid / in_stall    | in_word  (action, duration)
//  out_    | output    | out_valid / out_stall  | out_word (assigned_server, start_time,
//          |           |                        |           next_server, time_saturated)
//  cfg_    | apb slave | psel/penable/pready    | servers_in_use at byte address 0
//
//  a job while an unused server is left, and an end word then, skip the scan;
//  once all servers are used a word first passes the scan over n, the active server count,
//  which reads one finish time per cycle from the memory read port
//  one word is in flight at a time; the output register lets the next word in
//  while a result waits on out_stall
//  rst_n is synchronous; reset empties all servers, no clearing pass is needed
//  since only servers below the fill count are ever read
module earliest_free_server_dispatch_core import efsd_pkg::*; #(
  parameter int MAX_SERVERS = MAX_SERVERS_DEF,
  parameter int TIME_WIDTH  = TIME_WIDTH_DEF
) (
  input  logic              clk,
  input  logic              rst_n,
  // job and end words
  input  logic              in_valid,
  output logic              in_stall,
  input  in_word_t          in_word,
  // result words
  output logic              out_valid,
  input  logic              out_stall,
  output out_word_t         out_word,
  // configuration
  input  logic              cfg_psel,
  input  logic              cfg_penable,
  input  logic              cfg_pwrite,
  input  logic [APB_AW-1:0] cfg_paddr,
  input  logic [APB_DW-1:0] cfg_pwdata,
  output logic [APB_DW-1:0] cfg_prdata,
  output logic              cfg_pready
);

  localparam int IW    = (MAX_SERVERS > 1) ? $clog2(MAX_SERVERS) : 1;
  localparam int CW    = $clog2(MAX_SERVERS + 1);
  localparam int CMP_W = (CW > CFG_W) ? CW : CFG_W;

  logic [CFG_W-1:0]      servers_in_use_r, servers_in_use_nxt;
  logic                  cfg_sel_reg;
  logic                  cfg_wr;
  logic [CMP_W-1:0]      cfg_ext;
  logic [CW-1:0]         n_act;

  logic                  rd_en;
  logic [IW-1:0]         rd_addr;
  logic [TIME_WIDTH-1:0] rd_data;
  logic                  wr_en;
  logic [IW-1:0]         wr_addr;
  logic [TIME_WIDTH-1:0] wr_data;

  logic                  res_valid;
  logic                  res_ready;
  out_word_t             res_word;

  logic                  out_valid_r, out_valid_nxt;
  out_word_t             out_word_r;

  // apb register, always ready, writes beyond the register are dropped
  assign cfg_pready  = 1'b1;
  assign cfg_sel_reg = (cfg_paddr[APB_AW-1:2] == REG_SERVERS_IN_USE);
  assign cfg_wr      = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready;
  assign cfg_prdata  = cfg_sel_reg ? APB_DW'(servers_in_use_r) : '0;

  always_comb begin
    servers_in_use_nxt = servers_in_use_r;
    if (cfg_wr && cfg_sel_reg) begin
      servers_in_use_nxt = cfg_pwdata[CFG_W-1:0];
    end
  end

  // active count: zero counts as one, clamp at the server count
  assign cfg_ext = CMP_W'(servers_in_use_r);
  always_comb begin
    priority if (servers_in_use_r == '0) begin
      n_act = CW'(1);
    end else if (cfg_ext > CMP_W'(MAX_SERVERS)) begin
      n_act = CW'(MAX_SERVERS);
    end else begin
      n_act = CW'(servers_in_use_r);
    end
  end

  efsd_seq #(
    .MAX_SERVERS (MAX_SERVERS),
    .TIME_WIDTH  (TIME_WIDTH)
  ) u_seq (
    .clk       (clk),
    .rst_n     (rst_n),
    .n_act     (n_act),
    .in_valid  (in_valid),
    .in_word   (in_word),
    .in_stall  (in_stall),
    .rd_en     (rd_en),
    .rd_addr   (rd_addr),
    .rd_data   (rd_data),
    .wr_en     (wr_en),
    .wr_addr   (wr_addr),
    .wr_data   (wr_data),
    .res_valid (res_valid),
    .res_ready (res_ready),
    .res_word  (res_word)
  );

  // finish time per server
  efsd_ftmem #(
    .DEPTH (MAX_SERVERS),
    .WIDTH (TIME_WIDTH)
  ) u_ftmem (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  // output register: loads when empty or when its word leaves this cycle
  assign res_ready = !out_valid_r || !out_stall;

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (res_ready) begin
      out_valid_nxt = res_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      servers_in_use_r <= SERVERS_IN_USE_RST;
      out_valid_r      <= 1'b0;
    end else begin
      servers_in_use_r <= servers_in_use_nxt;
      out_valid_r      <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (res_ready && res_valid) begin
      out_word_r <= res_word;
    end
  end

  assign out_valid = out_valid_r;
  assign out_word  = out_word_r;

endmodule
